/* rtl/core/pcri_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcri_pkg: shared types and constants of the ramped-integral PID controller
// Field widths, register indexes, datapath widths and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcri_pkg;

  // Input and result fields
  localparam int unsigned ERR_W   = 32;
  localparam int unsigned DT_W    = 16;
  localparam int unsigned DRIVE_W = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned LIM_W      = 31;
  localparam int unsigned RAMP_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DRIVE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TIME    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INCR_MODE    = 3'd6;

  localparam logic [LIM_W-1:0]  LIM_RESET  = 31'h7FFF_FFFF;
  localparam logic [RAMP_W-1:0] RAMP_RESET = 16'd1000;

  // Integral: Q8.16 within +-100
  localparam int unsigned INTEG_W = 24;
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 24'sd6553600;
  localparam int unsigned STEP_W  = 31;
  // 100 in Q16.16 over the Q8.8 time scale
  localparam logic [STEP_W-1:0] STEP_SCALE = 31'd25600;

  // Shared divider: 42-bit dividend, 16-bit divisor, two bits a cycle
  localparam int unsigned DIV_W    = 42;
  localparam int unsigned DVS_W    = 16;
  localparam int unsigned DIV_ITER = DIV_W / 2;
  localparam int unsigned DCNT_W   = 5;

  // Derivative, products and sum
  localparam int unsigned DIFF_W  = 33;
  localparam int unsigned DERIV_W = 42;
  localparam int unsigned MULA_W  = GAIN_W + 1;
  localparam int unsigned PROD_W  = MULA_W + DERIV_W;
  localparam int unsigned ACC_W   = 60;
  localparam int unsigned SCL_W   = ACC_W - 8;
  localparam int unsigned OFF_W   = 54;

  // Operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MUL_PROP  = 2'd0,
    MUL_INTEG = 2'd1,
    MUL_DERIV = 2'd2
  } mul_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     capture;
    logic     div_go;
    logic     div_deriv;
    logic     take_step;
    logic     take_deriv;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     scale;
    logic     offset;
    logic     finish;
  } pcri_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_busy;
    logic out_busy;
  } pcri_sts_t;

endpackage
`default_nettype wire

/* rtl/core/pcri_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcri_if: stream channels of the ramped-integral PID controller
// One channel for input items (error and elapsed time) and one for results.
// ----------------------------------------------------------------------------
interface pcri_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [pcri_pkg::ERR_W-1:0] error_value;
  logic        [pcri_pkg::DT_W-1:0]  elapsed_time;

  modport source (output valid, output error_value, output elapsed_time, input ready);
  modport sink   (input valid, input error_value, input elapsed_time, output ready);
endinterface

interface pcri_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcri_pkg::DRIVE_W-1:0] drive_value;
  logic                                limited;

  modport source (output valid, output drive_value, output limited, input ready);
  modport sink   (input valid, input drive_value, input limited, output ready);
endinterface
`default_nettype wire

/* rtl/core/pcri_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcri_div: unsigned restoring divider, two quotient bits per cycle
// Loads dividend and divisor on start, shifts the quotient into the dividend
// register and drops busy once all bits are done. Divisor must be non-zero.
// ----------------------------------------------------------------------------
module pcri_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [pcri_pkg::DIV_W-1:0]      dividend_i,
  input  wire logic [pcri_pkg::DVS_W-1:0]      divisor_i,
  output logic                                 busy_o,
  output logic [pcri_pkg::DIV_W-1:0]           quotient_o
);

  logic [pcri_pkg::DIV_W-1:0]  sh_q, sh_d;
  logic [pcri_pkg::DVS_W-1:0]  rem_q, rem_d;
  logic [pcri_pkg::DVS_W-1:0]  dvs_q;
  logic [pcri_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;

  logic [pcri_pkg::DVS_W:0] r1, r2, r1n, r2n;
  logic                     ge1, ge2;

  // Two restoring steps on the top dividend bits
  always_comb begin
    r1  = {rem_q, sh_q[pcri_pkg::DIV_W-1]};
    ge1 = (r1 >= {1'b0, dvs_q});
    r1n = ge1 ? (r1 - {1'b0, dvs_q}) : r1;
    r2  = {r1n[pcri_pkg::DVS_W-1:0], sh_q[pcri_pkg::DIV_W-2]};
    ge2 = (r2 >= {1'b0, dvs_q});
    r2n = ge2 ? (r2 - {1'b0, dvs_q}) : r2;
  end

  // Load on start, advance while busy
  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      sh_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = pcri_pkg::DCNT_W'(pcri_pkg::DIV_ITER);
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d  = {sh_q[pcri_pkg::DIV_W-3:0], ge1, ge2};
      rem_d = r2n[pcri_pkg::DVS_W-1:0];
      cnt_d = cnt_q - pcri_pkg::DCNT_W'(1);
      if (cnt_q == pcri_pkg::DCNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = sh_q;

endmodule
`default_nettype wire

/* rtl/core/pcri_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcri_datapath: registers and arithmetic of the ramped-integral PID
// Holds configuration and loop state, drives the shared divider and the
// shared multiplier, and owns the result register.
// ----------------------------------------------------------------------------
module pcri_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire pcri_pkg::pcri_cmd_t                  cmd_i,
  output pcri_pkg::pcri_sts_t                       sts_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [pcri_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [pcri_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic signed [pcri_pkg::ERR_W-1:0]    error_value_i,
  input  wire logic [pcri_pkg::DT_W-1:0]            elapsed_time_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [pcri_pkg::DRIVE_W-1:0]       drive_value_o,
  output logic                                      limited_o
);

  // Configuration registers
  logic [pcri_pkg::GAIN_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [pcri_pkg::LIM_W-1:0]  output_limit_q, min_drive_q;
  logic [pcri_pkg::RAMP_W-1:0] ramp_time_q;
  logic                        incr_mode_q;

  // Loop state
  logic signed [pcri_pkg::INTEG_W-1:0] integ_q, integ_d;
  logic signed [pcri_pkg::ERR_W-1:0]   prev_err_q;
  logic signed [pcri_pkg::DRIVE_W-1:0] prev_out_q;

  // Per-item working registers
  logic signed [pcri_pkg::ERR_W-1:0]   err_q;
  logic [pcri_pkg::DT_W-1:0]           dt_q;
  logic signed [pcri_pkg::DERIV_W-1:0] deriv_q, deriv_d;
  logic signed [pcri_pkg::PROD_W-1:0]  prod_q;
  logic signed [pcri_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic signed [pcri_pkg::SCL_W-1:0]   scaled_q, scaled_d;
  logic signed [pcri_pkg::OFF_W-1:0]   off_q, off_d;

  // Result register
  logic                                out_valid_q, out_valid_d;
  logic signed [pcri_pkg::DRIVE_W-1:0] drive_q, drive_d;
  logic                                limited_q, limited_d;

  // Divider signals
  logic [pcri_pkg::DIV_W-1:0] div_dividend, div_quot;
  logic [pcri_pkg::DVS_W-1:0] div_divisor, ramp_eff;
  logic                       div_busy;
  logic [pcri_pkg::STEP_W-1:0] step_dividend;
  logic signed [pcri_pkg::DIFF_W-1:0] diff;
  logic [pcri_pkg::DIFF_W-1:0]        diff_mag;

  // Multiplier signals
  logic signed [pcri_pkg::MULA_W-1:0]  mul_a;
  logic signed [pcri_pkg::DERIV_W-1:0] mul_b;
  logic signed [pcri_pkg::PROD_W-1:0]  mul_p;

  // Integral update signals
  logic signed [pcri_pkg::STEP_W+1:0]  integ_sum, step_s;

  // Offset and clamp signals
  logic signed [pcri_pkg::ACC_W-1:0] acc_rnd;
  logic signed [pcri_pkg::OFF_W-1:0] min_s, prev_s, lim_s;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= '0;
      integ_gain_q   <= '0;
      deriv_gain_q   <= '0;
      output_limit_q <= pcri_pkg::LIM_RESET;
      min_drive_q    <= '0;
      ramp_time_q    <= pcri_pkg::RAMP_RESET;
      incr_mode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcri_pkg::CFG_PROP_GAIN:    prop_gain_q    <= cfg_data_i[pcri_pkg::GAIN_W-1:0];
        pcri_pkg::CFG_INTEG_GAIN:   integ_gain_q   <= cfg_data_i[pcri_pkg::GAIN_W-1:0];
        pcri_pkg::CFG_DERIV_GAIN:   deriv_gain_q   <= cfg_data_i[pcri_pkg::GAIN_W-1:0];
        pcri_pkg::CFG_OUTPUT_LIMIT: output_limit_q <= cfg_data_i[pcri_pkg::LIM_W-1:0];
        pcri_pkg::CFG_MIN_DRIVE:    min_drive_q    <= cfg_data_i[pcri_pkg::LIM_W-1:0];
        pcri_pkg::CFG_RAMP_TIME:    ramp_time_q    <= cfg_data_i[pcri_pkg::RAMP_W-1:0];
        pcri_pkg::CFG_INCR_MODE:    incr_mode_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Divider operands: integral step, then derivative magnitude
  always_comb begin
    ramp_eff      = (ramp_time_q == '0) ? pcri_pkg::DVS_W'(1) : ramp_time_q;
    step_dividend = pcri_pkg::STEP_W'(dt_q) * pcri_pkg::STEP_SCALE;
    diff          = pcri_pkg::DIFF_W'(err_q) - pcri_pkg::DIFF_W'(prev_err_q);
    diff_mag      = diff[pcri_pkg::DIFF_W-1] ? pcri_pkg::DIFF_W'(-diff)
                                             : pcri_pkg::DIFF_W'(diff);
    if (cmd_i.div_deriv) begin
      div_dividend = {1'b0, diff_mag, 8'b0};
      div_divisor  = dt_q;
    end else begin
      div_dividend = pcri_pkg::DIV_W'(step_dividend);
      div_divisor  = ramp_eff;
    end
  end

  pcri_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // Ramp the integral toward the sign of the error and clamp to +-100
  always_comb begin
    step_s    = $signed({2'b00, div_quot[pcri_pkg::STEP_W-1:0]});
    integ_sum = (pcri_pkg::STEP_W+2)'(integ_q);
    if (err_q > 0) begin
      integ_sum = integ_sum + step_s;
    end else if (err_q < 0) begin
      integ_sum = integ_sum - step_s;
    end
    if (integ_sum > (pcri_pkg::STEP_W+2)'(pcri_pkg::INTEG_MAX)) begin
      integ_d = pcri_pkg::INTEG_MAX;
    end else if (integ_sum < -(pcri_pkg::STEP_W+2)'(pcri_pkg::INTEG_MAX)) begin
      integ_d = -pcri_pkg::INTEG_MAX;
    end else begin
      integ_d = pcri_pkg::INTEG_W'(integ_sum);
    end
    deriv_d = diff[pcri_pkg::DIFF_W-1] ? -$signed(div_quot) : $signed(div_quot);
  end

  // Shared multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      pcri_pkg::MUL_PROP: begin
        mul_a = $signed({1'b0, prop_gain_q});
        mul_b = pcri_pkg::DERIV_W'(err_q);
      end
      pcri_pkg::MUL_INTEG: begin
        mul_a = $signed({1'b0, integ_gain_q});
        mul_b = pcri_pkg::DERIV_W'(integ_q);
      end
      pcri_pkg::MUL_DERIV: begin
        mul_a = $signed({1'b0, deriv_gain_q});
        mul_b = deriv_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = pcri_pkg::PROD_W'(mul_a) * pcri_pkg::PROD_W'(mul_b);
  end

  // Accumulate, scale toward zero, offset, clamp
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_load) begin
      acc_d = pcri_pkg::ACC_W'(prod_q);
    end else if (cmd_i.acc_add) begin
      acc_d = acc_q + pcri_pkg::ACC_W'(prod_q);
    end

    acc_rnd  = acc_q[pcri_pkg::ACC_W-1] ? (acc_q + pcri_pkg::ACC_W'(255)) : acc_q;
    scaled_d = acc_rnd[pcri_pkg::ACC_W-1:8];

    min_s  = $signed({{(pcri_pkg::OFF_W-pcri_pkg::LIM_W){1'b0}}, min_drive_q});
    prev_s = incr_mode_q ? pcri_pkg::OFF_W'(prev_out_q) : '0;
    off_d  = scaled_q[pcri_pkg::SCL_W-1] ? (pcri_pkg::OFF_W'(scaled_q) - min_s + prev_s)
                                         : (pcri_pkg::OFF_W'(scaled_q) + min_s + prev_s);

    lim_s = $signed({{(pcri_pkg::OFF_W-pcri_pkg::LIM_W){1'b0}}, output_limit_q});
    if (off_q > lim_s) begin
      drive_d   = pcri_pkg::DRIVE_W'(lim_s);
      limited_d = 1'b1;
    end else if (off_q < -lim_s) begin
      drive_d   = pcri_pkg::DRIVE_W'(-lim_s);
      limited_d = 1'b1;
    end else begin
      drive_d   = pcri_pkg::DRIVE_W'(off_q);
      limited_d = 1'b0;
    end
  end

  // Result handshake: drop on transfer, set when the controller finishes
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      prev_err_q  <= '0;
      prev_out_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.take_step) begin
        integ_q <= integ_d;
      end
      if (cmd_i.finish) begin
        prev_err_q <= err_q;
        prev_out_q <= drive_d;
      end
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      err_q <= error_value_i;
      dt_q  <= (elapsed_time_i == '0) ? pcri_pkg::DT_W'(1) : elapsed_time_i;
    end
    if (cmd_i.take_deriv) begin
      deriv_q <= deriv_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
    acc_q <= acc_d;
    if (cmd_i.scale) begin
      scaled_q <= scaled_d;
    end
    if (cmd_i.offset) begin
      off_q <= off_d;
    end
    if (cmd_i.finish) begin
      drive_q   <= drive_d;
      limited_q <= limited_d;
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign drive_value_o  = drive_q;
  assign limited_o      = limited_q;

endmodule
`default_nettype wire

/* rtl/core/pcri_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcri_ctrl: sequencer of the ramped-integral PID
// Steps one item through the two divisions, the three gain products, the
// scaling, offset and clamp, and hands the result to the output register.
// ----------------------------------------------------------------------------
module pcri_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire pcri_pkg::pcri_sts_t  sts_i,
  output pcri_pkg::pcri_cmd_t       cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_DIVI_GO   = 12'b0000_0000_0010,
    ST_DIVI_WAIT = 12'b0000_0000_0100,
    ST_DIVD_GO   = 12'b0000_0000_1000,
    ST_DIVD_WAIT = 12'b0000_0001_0000,
    ST_MUL0      = 12'b0000_0010_0000,
    ST_MUL1      = 12'b0000_0100_0000,
    ST_MUL2      = 12'b0000_1000_0000,
    ST_MUL3      = 12'b0001_0000_0000,
    ST_SCALE     = 12'b0010_0000_0000,
    ST_OFFSET    = 12'b0100_0000_0000,
    ST_FINISH    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DIVI_GO;
        end
      end
      ST_DIVI_GO: begin
        cmd_o.div_go = 1'b1;
        state_d      = ST_DIVI_WAIT;
      end
      ST_DIVI_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.take_step = 1'b1;
          state_d         = ST_DIVD_GO;
        end
      end
      ST_DIVD_GO: begin
        cmd_o.div_go    = 1'b1;
        cmd_o.div_deriv = 1'b1;
        state_d         = ST_DIVD_WAIT;
      end
      ST_DIVD_WAIT: begin
        cmd_o.div_deriv = 1'b1;
        if (!sts_i.div_busy) begin
          cmd_o.take_deriv = 1'b1;
          state_d          = ST_MUL0;
        end
      end
      ST_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pcri_pkg::MUL_PROP;
        state_d       = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = pcri_pkg::MUL_INTEG;
        cmd_o.acc_load = 1'b1;
        state_d        = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pcri_pkg::MUL_DERIV;
        cmd_o.acc_add = 1'b1;
        state_d       = ST_MUL3;
      end
      ST_MUL3: begin
        cmd_o.acc_add = 1'b1;
        state_d       = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_OFFSET;
      end
      ST_OFFSET: begin
        cmd_o.offset = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/pid_controller_ramp_integral.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_ramp_integral: PID controller with ramped integral
// Signed Q16.16 error and Q8.8 ms elapsed time in, clamped Q16.16 drive out.
//
//   channel  dir  handshake       payload
//   in_ch    in   valid / ready   error_value[31:0], elapsed_time[15:0]
//   out_ch   out  valid / ready   drive_value[31:0], limited
//   cfg      in   cfg_we_i        cfg_idx_i[2:0], cfg_data_i[30:0]
//
// One item at a time: each item passes through the shared divider (integral
// step, then derivative, each a start, a busy wait and a take) and the shared
// multiplier (three products in sequence), then scale, offset, finish.
// Reset clears the configuration to its defaults and the loop state to zero.
// A new item is taken while a result waits; the item completes only once
// the output register has been freed.
// ----------------------------------------------------------------------------
module pid_controller_ramp_integral (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  pcri_in_if.sink                              in_ch,
  pcri_out_if.source                           out_ch,
  input  wire logic                            cfg_we_i,
  input  wire logic [pcri_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pcri_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  pcri_pkg::pcri_cmd_t cmd;
  pcri_pkg::pcri_sts_t sts;

  pcri_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcri_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .error_value_i  (in_ch.error_value),
    .elapsed_time_i (in_ch.elapsed_time),
    .out_valid_o    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .drive_value_o  (out_ch.drive_value),
    .limited_o      (out_ch.limited)
  );

endmodule
`default_nettype wire

/* rtl/core/pcri_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcri_checker: port-level checks of the ramped-integral PID
// Watches the channel handshakes and result payload of the top level.
// ----------------------------------------------------------------------------
module pcri_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_i,
  input wire logic                                out_valid_i,
  input wire logic                                out_ready_i,
  input wire logic signed [pcri_pkg::DRIVE_W-1:0] drive_value_i
);

  // Hold a result until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // Block works on one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an item is at work");

  // No result can appear in the cycle after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared too early");

  // Clamp is symmetric and at most 2^31-1, so the most negative code never shows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> drive_value_i != 32'sh8000_0000)
    else $error("drive outside the symmetric clamp");

endmodule

bind pid_controller_ramp_integral pcri_checker u_pcri_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .drive_value_i (out_ch.drive_value)
);
`default_nettype wire
